// ===== hdl/cuh_pkg.sv =====
// Shared package for the cone uplift heightfield block.
// Constants, register and action codes, hotspot record and state type.
package cuh_pkg;

	localparam int MAX_HOTSPOTS = 16;
	localparam int GRID_DIM_MAX = 4096;
	localparam int IDX_W = (MAX_HOTSPOTS > 1) ? $clog2(MAX_HOTSPOTS) : 1;
	localparam int CNT_W = $clog2(MAX_HOTSPOTS + 1);
	localparam int ELEV_MAX = 8388607;

	typedef logic [1:0] action_t;
	localparam action_t ACT_CLEAR = 2'd0;
	localparam action_t ACT_LOAD  = 2'd1;
	localparam action_t ACT_CELL  = 2'd2;
	localparam action_t ACT_NONE  = 2'd3;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_SEA_LEVEL   = 3'd0;
	localparam reg_idx_t REG_ORIGIN_X    = 3'd1;
	localparam reg_idx_t REG_ORIGIN_Z    = 3'd2;
	localparam reg_idx_t REG_CELL_WIDTH  = 3'd3;
	localparam reg_idx_t REG_CELL_HEIGHT = 3'd4;
	localparam reg_idx_t REG_GRID_WIDTH  = 3'd5;
	localparam reg_idx_t REG_GRID_HEIGHT = 3'd6;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] z;
		logic [23:0] peak;
		logic [23:0] radius;
	} hotspot_t;

	localparam int HS_W = $bits(hotspot_t);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_CENTER = 10'b0000000010,
		S_READ   = 10'b0000000100,
		S_CHECK  = 10'b0000001000,
		S_SQR    = 10'b0000010000,
		S_SQRT   = 10'b0000100000,
		S_MUL    = 10'b0001000000,
		S_DIV    = 10'b0010000000,
		S_FINISH = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

endpackage

// ===== hdl/cuh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module cuh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                  wdata,
	input  logic                              re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// ===== hdl/cuh_sqrt.sv =====
// Iterative floor square root, two radicand bits per cycle.
// Uses cuh_pkg.
module cuh_sqrt import cuh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] radicand,
	output logic        done,
	output logic [23:0] root
);
	logic [47:0] rad_q;
	logic [25:0] rem_q;
	logic [23:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [27:0] rem_n;
	logic [27:0] trial;
	logic        ge;

	assign rem_n = {rem_q, rad_q[47:46]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = rem_n >= trial;
	assign done  = done_q;
	assign root  = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd24;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[45:0], 2'b00};
			if (ge) begin
				rem_q  <= 26'(rem_n - trial);
				root_q <= {root_q[22:0], 1'b1};
			end else begin
				rem_q  <= rem_n[25:0];
				root_q <= {root_q[22:0], 1'b0};
			end
		end
	end
endmodule

// ===== hdl/cuh_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Uses cuh_pkg.
module cuh_div import cuh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] numer,
	input  logic [23:0] denom,
	output logic        done,
	output logic [47:0] quot
);
	logic [47:0] num_q;
	logic [23:0] den_q;
	logic [23:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [24:0] rem_n;
	logic        ge;

	assign rem_n = {rem_q, num_q[47]};
	assign ge    = rem_n >= {1'b0, den_q};
	assign done  = done_q;
	assign quot  = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= 24'(rem_n - {1'b0, den_q});
				num_q <= {num_q[46:0], 1'b1};
			end else begin
				rem_q <= rem_n[23:0];
				num_q <= {num_q[46:0], 1'b0};
			end
		end
	end
endmodule

// ===== hdl/cone_uplift_heightfield.sv =====
// Top level of the cone uplift heightfield block: registers, sequencer, table.
// Uses cuh_pkg, cuh_ram, cuh_sqrt, cuh_div.
//
// One word in, one word out. Clear, load and pass-through cells go
// straight from idle to the done state. An interior cell above sea level
// walks the hotspot table in order, one entry at a time; a covering
// hotspot runs the 24-step square root and the 48-step divider in series,
// while a skipped one runs neither.
// A finished result waits in the output register while the next word is
// taken. The table RAM needs no clearing; only entries below the count are
// used.
module cone_uplift_heightfield import cuh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic signed [31:0] hotspot_x,
	input  logic signed [31:0] hotspot_z,
	input  logic signed [23:0] hotspot_peak,
	input  logic signed [23:0] hotspot_radius,
	input  logic [11:0]        cell_column,
	input  logic [11:0]        cell_row,
	input  logic signed [23:0] cell_elevation,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] new_elevation,
	output logic               raised,
	output logic               load_dropped
);
	logic signed [23:0] sea_level_q;
	logic signed [31:0] origin_x_q;
	logic signed [31:0] origin_z_q;
	logic [23:0]        cell_width_q;
	logic [23:0]        cell_height_q;
	logic [12:0]        grid_width_q;
	logic [12:0]        grid_height_q;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic [11:0]        col_q;
	logic [11:0]        row_q;
	logic signed [23:0] elev_q;
	logic signed [38:0] cx2_q;
	logic signed [38:0] cz2_q;
	logic [23:0]        dxa_q;
	logic [23:0]        dza_q;
	logic [23:0]        r2_q;
	logic [23:0]        peak_q;
	logic [23:0]        diff_q;
	logic [23:0]        best_q;
	logic [23:0]        res_elev_q;
	logic               res_raised_q;
	logic               res_drop_q;
	logic               out_valid_q;

	logic               accept;
	logic               cfg_we;
	logic [12:0]        gw;
	logic [12:0]        gh;
	logic               interior;
	logic               full;
	logic               ram_we;
	logic               ram_re;
	logic [HS_W-1:0]    ram_rdata;
	hotspot_t           hs;
	hotspot_t           hs_in;
	logic [23:0]        r2;
	logic signed [39:0] dx;
	logic signed [39:0] dz;
	logic [39:0]        adx;
	logic [39:0]        adz;
	logic               skip_chk;
	logic [48:0]        ssum;
	logic [47:0]        rr;
	logic               skip_sqr;
	logic               sq_start;
	logic               sq_done;
	logic [23:0]        sq_root;
	logic signed [48:0] prod;
	logic [47:0]        prod_mag;
	logic               dv_start;
	logic               dv_done;
	logic [47:0]        dv_quot;
	logic signed [24:0] sum;
	logic               out_free;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;
	assign in_stall  = state_q != S_IDLE;
	assign accept    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign full      = count_q >= CNT_W'(MAX_HOTSPOTS);

	assign gw = (grid_width_q > 13'(GRID_DIM_MAX)) ? 13'(GRID_DIM_MAX) : grid_width_q;
	assign gh = (grid_height_q > 13'(GRID_DIM_MAX)) ? 13'(GRID_DIM_MAX) : grid_height_q;
	assign interior = (gw >= 13'd3) && (gh >= 13'd3) && (cell_width_q != '0)
		&& (cell_height_q != '0) && (cell_column != '0) && (cell_row != '0)
		&& ({1'b0, cell_column} < gw - 13'd1) && ({1'b0, cell_row} < gh - 13'd1)
		&& (cell_elevation > sea_level_q);

	assign hs_in.x      = hotspot_x;
	assign hs_in.z      = hotspot_z;
	assign hs_in.peak   = hotspot_peak;
	assign hs_in.radius = hotspot_radius;
	assign ram_we = accept && (action == ACT_LOAD) && !full;
	assign ram_re = (state_q == S_READ);

	cuh_ram #(.WIDTH(HS_W), .DEPTH(MAX_HOTSPOTS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (hs_in),
		.re    (ram_re),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign hs  = hotspot_t'(ram_rdata);
	assign r2  = {hs.radius[22:0], 1'b0};
	assign dx  = {cx2_q[38], cx2_q} - {{7{hs.x[31]}}, hs.x, 1'b0};
	assign dz  = {cz2_q[38], cz2_q} - {{7{hs.z[31]}}, hs.z, 1'b0};
	assign adx = dx[39] ? 40'(-dx) : 40'(dx);
	assign adz = dz[39] ? 40'(-dz) : 40'(dz);
	assign skip_chk = hs.radius[23] || (hs.radius == '0)
		|| (adx >= {16'b0, r2}) || (adz >= {16'b0, r2});

	assign ssum     = 49'(dxa_q * dxa_q) + 49'(dza_q * dza_q);
	assign rr       = r2_q * r2_q;
	assign skip_sqr = ssum >= {1'b0, rr};
	assign sq_start = (state_q == S_SQR) && !skip_sqr;

	cuh_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (ssum[47:0]),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign prod     = $signed(peak_q) * $signed({1'b0, diff_q});
	assign prod_mag = prod[48] ? 48'(-prod) : 48'(prod);
	assign dv_start = (state_q == S_MUL);

	cuh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.numer  (prod_mag),
		.denom  (r2_q),
		.done   (dv_done),
		.quot   (dv_quot)
	);

	assign sum = {elev_q[23], elev_q} + {1'b0, best_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sea_level_q   <= '0;
			origin_x_q    <= '0;
			origin_z_q    <= '0;
			cell_width_q  <= 24'd256;
			cell_height_q <= 24'd256;
			grid_width_q  <= '0;
			grid_height_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEA_LEVEL:   sea_level_q   <= cfg_data[23:0];
				REG_ORIGIN_X:    origin_x_q    <= cfg_data;
				REG_ORIGIN_Z:    origin_z_q    <= cfg_data;
				REG_CELL_WIDTH:  cell_width_q  <= cfg_data[23:0];
				REG_CELL_HEIGHT: cell_height_q <= cfg_data[23:0];
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data[12:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (action == ACT_CLEAR)
							count_q <= '0;
						else if (action == ACT_LOAD && !full)
							count_q <= count_q + CNT_W'(1);
						if (action == ACT_CELL && interior)
							state_q <= S_CENTER;
						else
							state_q <= S_DONE;
					end
				end
				S_CENTER: begin
					idx_q   <= '0;
					state_q <= S_READ;
				end
				S_READ: begin
					if (idx_q >= count_q)
						state_q <= S_FINISH;
					else
						state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (skip_chk) begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_READ;
					end else begin
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					if (skip_sqr) begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_READ;
					end else begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sq_done)
						state_q <= S_MUL;
				end
				S_MUL: state_q <= S_DIV;
				S_DIV: begin
					if (dv_done) begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_READ;
					end
				end
				S_FINISH: state_q <= S_DONE;
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				col_q        <= cell_column;
				row_q        <= cell_row;
				elev_q       <= cell_elevation;
				res_raised_q <= 1'b0;
				res_drop_q   <= (action == ACT_LOAD) && full;
				res_elev_q   <= (action == ACT_CELL) ? cell_elevation : '0;
			end
			S_CENTER: begin
				best_q <= '0;
				cx2_q  <= {{6{origin_x_q[31]}}, origin_x_q, 1'b0}
					+ 39'({col_q, 1'b1} * cell_width_q);
				cz2_q  <= {{6{origin_z_q[31]}}, origin_z_q, 1'b0}
					+ 39'({row_q, 1'b1} * cell_height_q);
			end
			S_CHECK: begin
				dxa_q  <= adx[23:0];
				dza_q  <= adz[23:0];
				r2_q   <= r2;
				peak_q <= hs.peak;
			end
			S_SQRT: begin
				if (sq_done)
					diff_q <= r2_q - sq_root;
			end
			S_DIV: begin
				if (dv_done && !peak_q[23] && (dv_quot > {24'b0, best_q}))
					best_q <= dv_quot[23:0];
			end
			S_FINISH: begin
				if (best_q != '0) begin
					res_raised_q <= 1'b1;
					res_elev_q   <= (sum[24] != sum[23]) ? 24'(ELEV_MAX) : sum[23:0];
				end
			end
			S_DONE: begin
				if (out_free) begin
					new_elevation <= res_elev_q;
					raised        <= res_raised_q;
					load_dropped  <= res_drop_q;
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== tb/sv/cone_uplift_heightfield_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for cone_uplift_heightfield: hotspot loads, clears and
// cell words checked against an in-bench cone uplift predictor. Uses cuh_pkg.
module cone_uplift_heightfield_tb;
	import cuh_pkg::*;

	typedef struct {
		logic [1:0]         act;
		logic signed [31:0] hx;
		logic signed [31:0] hz;
		logic signed [23:0] pk;
		logic signed [23:0] rad;
		logic [11:0]        col;
		logic [11:0]        row;
		logic signed [23:0] elev;
	} cell_word_t;

	typedef struct {
		logic signed [23:0] elev;
		logic               up;
		logic               drop;
	} uplift_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 0;
	logic signed [23:0] new_elevation;
	logic raised;
	logic load_dropped;
	cell_word_t drv = '{default: '0};

	cone_uplift_heightfield DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(drv.act), .hotspot_x(drv.hx), .hotspot_z(drv.hz),
		.hotspot_peak(drv.pk), .hotspot_radius(drv.rad),
		.cell_column(drv.col), .cell_row(drv.row), .cell_elevation(drv.elev),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_elevation(new_elevation), .raised(raised), .load_dropped(load_dropped)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// predictor state
	longint cone_x[MAX_HOTSPOTS];
	longint cone_z[MAX_HOTSPOTS];
	longint cone_peak[MAX_HOTSPOTS];
	longint cone_rad[MAX_HOTSPOTS];
	int cone_cnt = 0;
	longint m_sea = 0, m_ox = 0, m_oz = 0, m_cw = 256, m_ch = 256, m_gw = 0, m_gh = 0;

	cell_word_t  pend_words[$];
	uplift_res_t want_elev[$];
	int errors = 0;
	bit in_took = 0;
	int hold_req = 0;

	function automatic void add_word(input cell_word_t w);
		pend_words.insert(pend_words.size(), w);
	endfunction

	function automatic longint floor_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint best_cone(longint cx2, longint cz2);
		longint best, r2, dx2, dz2, s, d, c;
		best = 0;
		for (int i = 0; i < cone_cnt; i++) begin
			if (cone_rad[i] <= 0) continue;
			r2 = 2 * cone_rad[i];
			dx2 = cx2 - 2 * cone_x[i];
			dz2 = cz2 - 2 * cone_z[i];
			if ((dx2 < 0 ? -dx2 : dx2) >= r2 || (dz2 < 0 ? -dz2 : dz2) >= r2) continue;
			s = dx2 * dx2 + dz2 * dz2;
			if (s >= r2 * r2) continue;
			d = floor_sqrt(s);
			c = (cone_peak[i] * (r2 - d)) / r2;
			if (c > best) best = c;
		end
		return best;
	endfunction

	task automatic apply_word(input cell_word_t w, output uplift_res_t r);
		longint gw, gh, col, row, e, add, res;
		r = '{elev: '0, up: 1'b0, drop: 1'b0};
		case (w.act)
			ACT_CLEAR: cone_cnt = 0;
			ACT_LOAD: begin
				if (cone_cnt >= MAX_HOTSPOTS) begin
					r.drop = 1'b1;
				end else begin
					cone_x[cone_cnt] = longint'(w.hx);
					cone_z[cone_cnt] = longint'(w.hz);
					cone_peak[cone_cnt] = longint'(w.pk);
					cone_rad[cone_cnt] = longint'(w.rad);
					cone_cnt++;
				end
			end
			ACT_CELL: begin
				gw = m_gw > GRID_DIM_MAX ? GRID_DIM_MAX : m_gw;
				gh = m_gh > GRID_DIM_MAX ? GRID_DIM_MAX : m_gh;
				col = longint'(w.col);
				row = longint'(w.row);
				e = longint'(w.elev);
				res = e;
				if (gw >= 3 && gh >= 3 && m_cw != 0 && m_ch != 0 && col >= 1 &&
				    col < gw - 1 && row >= 1 && row < gh - 1 && e > m_sea) begin
					add = best_cone(2 * m_ox + (2 * col + 1) * m_cw,
					                2 * m_oz + (2 * row + 1) * m_ch);
					if (add > 0) begin
						res = e + add;
						if (res > ELEV_MAX) res = ELEV_MAX;
						if (res < -ELEV_MAX - 1) res = -ELEV_MAX - 1;
						r.up = 1'b1;
					end
				end
				r.elev = res[23:0];
			end
			default: ;
		endcase
	endtask

	// driver: bursts of words with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		cell_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (pend_words.size() > 0) begin
			w = pend_words.pop_front();
			drv <= w;
			in_valid <= 1'b1;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
			end else begin
				burst_left--;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver stall pattern plus the long hold-off
	int hold_seen = 0;
	int hold_left = 0;
	int rx_mode = 0;
	int rx_cnt = 0;
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = 3000;
		end
		if (rx_cnt == 0) begin
			rx_cnt = $urandom_range(20, 200);
			rx_mode = $urandom_range(0, 2);
		end else begin
			rx_cnt--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (rx_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// monitor, predictor hook and watchdog
	int quiet = 0;
	always @(posedge clk) begin
		uplift_res_t r, e;
		in_took = in_valid && !in_stall;
		if (in_took) begin
			apply_word(drv, r);
			want_elev.insert(want_elev.size(), r);
		end
		if (out_valid && !out_stall) begin
			if (want_elev.size() == 0) begin
				$display("%0t: unexpected word elev=%0d raised=%0b dropped=%0b",
				         $time, new_elevation, raised, load_dropped);
				errors++;
			end else begin
				e = want_elev.pop_front();
				if (new_elevation !== e.elev) begin
					$display("%0t: new_elevation exp %0d got %0d", $time, e.elev, new_elevation);
					errors++;
				end
				if (raised !== e.up) begin
					$display("%0t: raised exp %0b got %0b", $time, e.up, raised);
					errors++;
				end
				if (load_dropped !== e.drop) begin
					$display("%0t: load_dropped exp %0b got %0b", $time, e.drop, load_dropped);
					errors++;
				end
			end
		end
		if (in_took || (out_valid && !out_stall) || (cfg_valid && cfg_ready) || !arst_n)
			quiet = 0;
		else
			quiet++;
		if (quiet >= 40000) begin
			$display("cone_uplift_heightfield_tb: errors");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input longint val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[31:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SEA_LEVEL:   m_sea = longint'($signed(val[23:0]));
			REG_ORIGIN_X:    m_ox = longint'($signed(val[31:0]));
			REG_ORIGIN_Z:    m_oz = longint'($signed(val[31:0]));
			REG_CELL_WIDTH:  m_cw = val & 24'hFFFFFF;
			REG_CELL_HEIGHT: m_ch = val & 24'hFFFFFF;
			REG_GRID_WIDTH:  m_gw = val & 13'h1FFF;
			REG_GRID_HEIGHT: m_gh = val & 13'h1FFF;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pend_words.size() > 0 || want_elev.size() > 0 || in_valid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic cell_word_t mk(input logic [1:0] a, input longint x, input longint z,
	                                  input longint p, input longint rd, input int c,
	                                  input int rw, input longint e);
		cell_word_t w;
		w.act = a;
		w.hx = x[31:0];
		w.hz = z[31:0];
		w.pk = p[23:0];
		w.rad = rd[23:0];
		w.col = c[11:0];
		w.row = rw[11:0];
		w.elev = e[23:0];
		return w;
	endfunction

	function automatic cell_word_t noise_word();
		cell_word_t w;
		w.act = $urandom_range(0, 3);
		w.hx = $urandom;
		w.hz = $urandom;
		w.pk = $urandom;
		w.rad = $urandom;
		w.col = $urandom;
		w.row = $urandom;
		w.elev = $urandom;
		return w;
	endfunction

	// clear, a few cones near interior cells, then cells anywhere on the grid
	task automatic push_cluster(output int n_words);
		int nh, nc, c, rw, gw, gh;
		longint cx, cz, rd, e;
		gw = m_gw > GRID_DIM_MAX ? GRID_DIM_MAX : int'(m_gw);
		gh = m_gh > GRID_DIM_MAX ? GRID_DIM_MAX : int'(m_gh);
		if (gw < 3) gw = 3;
		if (gh < 3) gh = 3;
		n_words = 1;
		add_word(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		nh = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 5);
		for (int i = 0; i < nh; i++) begin
			c = $urandom_range(1, gw - 2);
			rw = $urandom_range(1, gh - 2);
			rd = (m_cw > 0 ? m_cw : 256) * $urandom_range(1, 12) / 2 + $urandom_range(0, 255);
			if (rd > 8388607) rd = $urandom_range(1, 8388607);
			if ($urandom_range(0, 11) == 0) rd = -longint'($urandom_range(0, 8388608));
			cx = m_ox + ((2 * c + 1) * m_cw) / 2 + $signed($urandom_range(0, 2 * rd)) - rd;
			cz = m_oz + ((2 * rw + 1) * m_ch) / 2 + $signed($urandom_range(0, 2 * rd)) - rd;
			add_word(mk(ACT_LOAD, cx, cz,
			    ($urandom_range(0, 5) == 0) ? $signed($urandom) : $urandom_range(1, 8388607),
			    rd, 0, 0, 0));
			n_words++;
		end
		nc = $urandom_range(3, 12);
		for (int i = 0; i < nc; i++) begin
			c = $urandom_range(0, gw - 1);
			rw = $urandom_range(0, gh - 1);
			e = ($urandom_range(0, 4) == 0) ? longint'($signed($urandom_range(0, 32'hFFFFFF) << 8) >>> 8)
			    : m_sea + $urandom_range(1, 4096);
			if (e > 8388607) e = 8388607;
			add_word(mk(ACT_CELL, 0, 0, 0, 0, c, rw, e));
			n_words++;
		end
	endtask

	longint phase_cfg[7][7] = '{
		'{0, 0, 0, 256, 256, 16, 16},
		'{-8388608, 0, 0, 256, 256, 64, 64},
		'{8388607, 1000, -1000, 16777215, 16777215, 4096, 4096},
		'{0, -2147483648, 2147483647, 1, 16777215, 8191, 3},
		'{100, -1000, 5000, 0, 256, 32, 32},
		'{-5000, 123456, -654321, 700, 300, 2, 40},
		'{0, 2147483647, -2147483648, 512, 384, 100, 100}
	};

	initial begin
		int n, total;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// defaults: zero-size grid passes everything through
		add_word(mk(ACT_CELL, 0, 0, 0, 0, 1, 1, 1000));
		add_word(mk(ACT_NONE, -1, -1, -1, -1, 4095, 4095, -1));
		drain();

		foreach (phase_cfg[p]) begin
			for (int r = 0; r < 7; r++)
				write_reg(reg_idx_t'(r), phase_cfg[p][r]);
			if (p == 0) begin
				add_word(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0));
				add_word(mk(ACT_LOAD, 2048 + 128, 2048 + 128, 25600, 1280, 0, 0, 0));
				add_word(mk(ACT_LOAD, 2048, 2048, 8388607, 0, 0, 0, 0));
				add_word(mk(ACT_LOAD, 2048, 2048, 8388607, -8388608, 0, 0, 0));
				add_word(mk(ACT_LOAD, 1000, 1000, -8388608, 8388607, 0, 0, 0));
				add_word(mk(ACT_CELL, 0, 0, 0, 0, 8, 8, 500));
				add_word(mk(ACT_CELL, 0, 0, 0, 0, 7, 8, 8388607));
				add_word(mk(ACT_CELL, 0, 0, 0, 0, 0, 8, 500));
				add_word(mk(ACT_CELL, 0, 0, 0, 0, 8, 0, 500));
				add_word(mk(ACT_CELL, 0, 0, 0, 0, 15, 8, 500));
				add_word(mk(ACT_CELL, 0, 0, 0, 0, 8, 15, 500));
				add_word(mk(ACT_CELL, 0, 0, 0, 0, 4095, 8, 500));
				add_word(mk(ACT_CELL, 0, 0, 0, 0, 8, 8, 0));
				add_word(mk(ACT_CELL, 0, 0, 0, 0, 8, 8, -8388608));
				add_word(mk(ACT_NONE, 0, 0, 0, 0, 8, 8, 500));
				for (int i = 0; i < 13; i++)
					add_word(mk(ACT_LOAD, 0, 0, 256, 256, 0, 0, 0));
				add_word(mk(ACT_LOAD, 5, 5, 5, 5, 0, 0, 0));
				add_word(mk(ACT_CELL, 0, 0, 0, 0, 1, 1, 1));
				drain();
			end
			if (p == 1) begin
				hold_req++;
				for (int i = 0; i < 12; i++)
					add_word(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0));
			end
			total = 0;
			while (total < 95) begin
				if ($urandom_range(0, 5) == 0) begin
					add_word(noise_word());
					total++;
				end else begin
					push_cluster(n);
					total += n;
				end
			end
			drain();
		end

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("cone_uplift_heightfield_tb: clean");
		else
			$display("cone_uplift_heightfield_tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/cuh_pkg.sv
hdl/cuh_ram.sv
hdl/cuh_sqrt.sv
hdl/cuh_div.sv
hdl/cone_uplift_heightfield.sv
tb/sv/cone_uplift_heightfield_tb.sv
